// ===== rtl/pcd_pkg.sv =====
// shared types and constants of the point to capsule distance core
package pcd_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;

    // |dy| needs two bits more than a coordinate at doubled scale
    localparam int YMAG_W   = COORD_BITS + 2;
    // sum of squares at doubled scale
    localparam int RAD_W    = 2 * COORD_BITS + 6;
    localparam int SQ_STEPS = RAD_W / 2;
    localparam int REM_W    = SQ_STEPS + 2;

    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_CENTRE_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTRE_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTRE_Z   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEG_LENGTH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CAP_RADIUS = 3'd4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] surface_distance;
        logic                         is_inside;
    } result_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] centre_x;
        logic signed [COORD_BITS-1:0] centre_y;
        logic signed [COORD_BITS-1:0] centre_z;
        logic        [COORD_BITS-2:0] segment_length;
        logic        [COORD_BITS-2:0] cap_radius;
    } cfg_t;

    // data handed from one square root cell to the next
    typedef struct packed {
        logic             valid;
        logic             in_cap;
        logic [RAD_W-1:0] radicand;
        logic [REM_W-1:0] rem;
        logic [SQ_STEPS-1:0] root;
    } sq_bus_t;

endpackage

// ===== rtl/pcd_regs.sv =====
// configuration register file with apb-style access
module pcd_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output pcd_pkg::cfg_t               cfg
);
    import pcd_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre_x       <= '0;
            cfg_reg.centre_y       <= '0;
            cfg_reg.centre_z       <= '0;
            cfg_reg.segment_length <= '0;
            cfg_reg.cap_radius     <= (COORD_BITS-1)'(1) << FRAC_BITS;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CENTRE_X:   cfg_reg.centre_x       <= pwdata;
                REG_CENTRE_Y:   cfg_reg.centre_y       <= pwdata;
                REG_CENTRE_Z:   cfg_reg.centre_z       <= pwdata;
                REG_SEG_LENGTH: cfg_reg.segment_length <= pwdata[COORD_BITS-2:0];
                REG_CAP_RADIUS: cfg_reg.cap_radius     <= pwdata[COORD_BITS-2:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CENTRE_X:   prdata = cfg_reg.centre_x;
            REG_CENTRE_Y:   prdata = cfg_reg.centre_y;
            REG_CENTRE_Z:   prdata = cfg_reg.centre_z;
            REG_SEG_LENGTH: prdata = {1'b0, cfg_reg.segment_length};
            REG_CAP_RADIUS: prdata = {1'b0, cfg_reg.cap_radius};
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== rtl/pcd_front.sv =====
// front pipeline: offsets, y clamp, squares, sum of squares and the inside test
module pcd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  pcd_pkg::point_t  point,
    input  pcd_pkg::cfg_t    cfg,
    output pcd_pkg::sq_bus_t bus
);
    import pcd_pkg::*;

    logic signed [COORD_BITS:0]   dx, dz;
    logic signed [COORD_BITS+2:0] y2, cy2, len, lo, hi, dy;
    logic [COORD_BITS-1:0]        mx_next, mz_next;
    logic [YMAG_W-1:0]            my_next;

    logic                         v1_reg, v2_reg, v3_reg, v4_reg;
    logic [COORD_BITS-1:0]        mx_reg, mz_reg;
    logic [YMAG_W-1:0]            my_reg;
    logic [2*COORD_BITS-1:0]      sqx_reg, sqz_reg, yl2_reg;
    logic [YMAG_W-1:0]            yhl_reg;
    logic [3:0]                   yh2_reg;
    logic [2*COORD_BITS-3:0]      rr_reg;
    logic [RAD_W-1:0]             s4_next, s4_reg, r4_reg;
    logic                         in_cap_reg;
    logic [RAD_W-1:0]             radicand_reg;

    // stage 1: offsets, y at doubled scale, y clamped onto the segment span
    always_comb
    begin
        dx  = $signed({point.point_x[COORD_BITS-1], point.point_x})
            - $signed({cfg.centre_x[COORD_BITS-1], cfg.centre_x});
        dz  = $signed({point.point_z[COORD_BITS-1], point.point_z})
            - $signed({cfg.centre_z[COORD_BITS-1], cfg.centre_z});
        y2  = $signed({{2{point.point_y[COORD_BITS-1]}}, point.point_y, 1'b0});
        cy2 = $signed({{2{cfg.centre_y[COORD_BITS-1]}}, cfg.centre_y, 1'b0});
        len = $signed((COORD_BITS+3)'(cfg.segment_length));
        lo  = cy2 - len;
        hi  = cy2 + len;
        if (y2 < lo)
            dy = y2 - lo;
        else if (y2 > hi)
            dy = y2 - hi;
        else
            dy = '0;
        mx_next = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        mz_next = dz[COORD_BITS] ? COORD_BITS'(-dz) : dz[COORD_BITS-1:0];
        my_next = dy[COORD_BITS+2] ? YMAG_W'(-dy) : dy[YMAG_W-1:0];
    end

    // stage 3 sum: x and z magnitudes are half of the doubled-scale value
    assign s4_next = (RAD_W'(sqx_reg) << 2) + (RAD_W'(sqz_reg) << 2) + RAD_W'(yl2_reg)
                   + (RAD_W'(yhl_reg) << (COORD_BITS+1))
                   + (RAD_W'(yh2_reg) << (2*COORD_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        mz_reg   <= mz_next;
        my_reg   <= my_next;
        sqx_reg  <= (2*COORD_BITS)'(mx_reg) * (2*COORD_BITS)'(mx_reg);
        sqz_reg  <= (2*COORD_BITS)'(mz_reg) * (2*COORD_BITS)'(mz_reg);
        yl2_reg  <= (2*COORD_BITS)'(my_reg[COORD_BITS-1:0])
                  * (2*COORD_BITS)'(my_reg[COORD_BITS-1:0]);
        yhl_reg  <= YMAG_W'(my_reg[YMAG_W-1:COORD_BITS]) * YMAG_W'(my_reg[COORD_BITS-1:0]);
        yh2_reg  <= 4'(my_reg[YMAG_W-1:COORD_BITS]) * 4'(my_reg[YMAG_W-1:COORD_BITS]);
        rr_reg   <= (2*COORD_BITS-2)'(cfg.cap_radius) * (2*COORD_BITS-2)'(cfg.cap_radius);
        s4_reg   <= s4_next;
        r4_reg   <= RAD_W'(rr_reg) << 2;
        in_cap_reg   <= (s4_reg <= r4_reg);
        radicand_reg <= s4_reg;
    end

    // first cell starts with an empty remainder and root
    always_comb
    begin
        bus          = '0;
        bus.valid    = v4_reg;
        bus.in_cap   = in_cap_reg;
        bus.radicand = radicand_reg;
    end

endmodule

// ===== rtl/pcd_sqrt_cell.sv =====
// one digit of the restoring square root, registered toward the next cell
module pcd_sqrt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  pcd_pkg::sq_bus_t bus_in,
    output pcd_pkg::sq_bus_t bus_out
);
    import pcd_pkg::*;

    logic [REM_W+1:0] cand;
    logic [REM_W+1:0] trial;
    logic [REM_W+2:0] diff;
    logic             take;
    sq_bus_t          bus_next;
    sq_bus_t          bus_reg;

    always_comb
    begin
        cand  = {bus_in.rem, bus_in.radicand[RAD_W-1 -: 2]};
        trial = (REM_W+2)'({bus_in.root, 2'b01});
        diff  = {1'b0, cand} - {1'b0, trial};
        take  = ~diff[REM_W+2];

        bus_next          = bus_in;
        bus_next.rem      = take ? diff[REM_W-1:0] : cand[REM_W-1:0];
        bus_next.root     = {bus_in.root[SQ_STEPS-2:0], take};
        bus_next.radicand = bus_in.radicand << 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bus_reg <= '0;
        else
            bus_reg <= bus_next;
    end

    assign bus_out = bus_reg;

endmodule

// ===== rtl/point_capsule_distance_core.sv =====
// top level: signed distance from a point to a y-aligned capsule surface
// pipeline from start to done: 4 front stages, one per root digit, 1 output
// throughput: one transaction per cycle; busy stays low, the pipeline never stalls
// the root is taken by a row of 35 cells, one result bit per cell and cycle
// the receiver cannot stall: every done pulse carries a result for one cycle only
// reset: asynchronous active-low; pipeline emptied, centre 0, length 0, radius 1.0
module point_capsule_distance_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  pcd_pkg::point_t             point,
    output logic                        done,
    output pcd_pkg::result_t            result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pcd_pkg::*;

    cfg_t    cfg;
    sq_bus_t chain [0:SQ_STEPS];

    // output stage signals
    logic [SQ_STEPS-2:0]        dist_half;
    logic signed [SQ_STEPS:0]   surf_wide;
    logic                       sat;
    result_t                    result_next;
    result_t                    result_reg;
    logic                       done_reg;

    // fully pipelined, so a new transaction is welcome in every cycle
    assign busy = 1'b0;

    pcd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // offsets, clamp, squares and the exact inside test
    pcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .point    (point),
        .cfg      (cfg),
        .bus      (chain[0])
    );

    // row of square root cells, each settling one root bit
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_cell
        pcd_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bus_in  (chain[i]),
            .bus_out (chain[i+1])
        );
    end

    // root is at doubled scale: halve, subtract radius, clip at the top
    always_comb
    begin
        dist_half = chain[SQ_STEPS].root[SQ_STEPS-1:1];
        surf_wide = $signed({2'b00, dist_half}) - $signed((SQ_STEPS+1)'(cfg.cap_radius));
        // distance can never fall below minus radius, only the top can overflow
        sat       = ~surf_wide[SQ_STEPS] & (|surf_wide[SQ_STEPS-1:COORD_BITS-1]);
        result_next.surface_distance = sat ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                           : surf_wide[COORD_BITS-1:0];
        result_next.is_inside        = chain[SQ_STEPS].in_cap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain[SQ_STEPS].valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sim/tb_top.sv =====
// testbench for point_capsule_distance_core: directed and random points checked against a predictor
module tb_top;
    import pcd_pkg::*;

    // spare register slot, writes to it must leave the capsule unchanged
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

    // pipeline is 40 deep, leave some margin when draining
    localparam int DRAIN_CYCLES = 60;

    localparam logic [COORD_BITS-1:0] MAX_SURFACE = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] ONE         = 1 << FRAC_BITS;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    point_t              point   = '0;
    logic                done;
    result_t             result;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // capsule as the testbench believes it is programmed, reset values
    cfg_t capsule_cfg = '{centre_x: '0, centre_y: '0, centre_z: '0,
                          segment_length: '0,
                          cap_radius: (COORD_BITS-1)'(1 << FRAC_BITS)};

    // distances still owed by the pipeline, oldest first
    result_t expected_distances[$];
    result_t oldest_distance;
    int      error_count = 0;

    point_capsule_distance_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .point   (point),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // surface distance and inside flag of one point against the capsule
    // y work is done at doubled scale so an odd segment length halves exactly
    function automatic result_t capsule_distance(input point_t p, input cfg_t c);
        longint       dx2, dz2, y2, y_lo, y_hi, y_near, dy2;
        logic [127:0] ax, ay, az, sum4, rad2, rad4, root, cand, half_root, limit, surf;
        result_t      r;
        dx2    = 2 * (longint'(p.point_x) - longint'(c.centre_x));
        dz2    = 2 * (longint'(p.point_z) - longint'(c.centre_z));
        y2     = 2 * longint'(p.point_y);
        y_lo   = 2 * longint'(c.centre_y) - longint'(c.segment_length);
        y_hi   = 2 * longint'(c.centre_y) + longint'(c.segment_length);
        // clamp the point's y onto the segment span
        y_near = (y2 < y_lo) ? y_lo : ((y2 > y_hi) ? y_hi : y2);
        dy2    = y2 - y_near;
        ax     = (dx2 < 0) ? -dx2 : dx2;
        ay     = (dy2 < 0) ? -dy2 : dy2;
        az     = (dz2 < 0) ? -dz2 : dz2;
        sum4   = ax * ax + ay * ay + az * az;
        rad2   = {c.cap_radius, 1'b0};
        rad4   = rad2 * rad2;
        // floor square root, one bit at a time from the top
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sum4)
                root = cand;
        end
        half_root = root >> 1;
        limit     = MAX_SURFACE + c.cap_radius;
        if (half_root > limit)
            surf = MAX_SURFACE;
        else
            surf = half_root - c.cap_radius;
        r.surface_distance = surf[COORD_BITS-1:0];
        r.is_inside        = (sum4 <= rad4);
        return r;
    endfunction

    // compare every result transaction with the oldest owed distance
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_distances.size() == 0)
            begin
                $error("unexpected transaction: surface_distance %0d is_inside %0b",
                       result.surface_distance, result.is_inside);
                error_count++;
            end
            else
            begin
                oldest_distance = expected_distances.pop_front();
                if (result.surface_distance !== oldest_distance.surface_distance)
                begin
                    $error("surface_distance: expected %0d, got %0d",
                           oldest_distance.surface_distance, result.surface_distance);
                    error_count++;
                end
                if (result.is_inside !== oldest_distance.is_inside)
                begin
                    $error("is_inside: expected %0b, got %0b",
                           oldest_distance.is_inside, result.is_inside);
                    error_count++;
                end
            end
        end
    end

    // one apb write, setup then access phase, then the bus returns to idle
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CENTRE_X:   capsule_cfg.centre_x       = value;
            REG_CENTRE_Y:   capsule_cfg.centre_y       = value;
            REG_CENTRE_Z:   capsule_cfg.centre_z       = value;
            REG_SEG_LENGTH: capsule_cfg.segment_length = value[COORD_BITS-2:0];
            REG_CAP_RADIUS: capsule_cfg.cap_radius     = value[COORD_BITS-2:0];
            default: ;
        endcase
    endtask

    task automatic write_capsule(input logic [31:0] cx, input logic [31:0] cy,
                                 input logic [31:0] cz, input logic [31:0] len,
                                 input logic [31:0] rad);
        write_reg(REG_CENTRE_X, cx);
        write_reg(REG_CENTRE_Y, cy);
        write_reg(REG_CENTRE_Z, cz);
        write_reg(REG_SEG_LENGTH, len);
        write_reg(REG_CAP_RADIUS, rad);
    endtask

    // hand one point to the core; start stays high so back-to-back points stream
    task automatic send_point(input point_t p);
        start <= 1'b1;
        point <= p;
        do @(posedge clk); while (busy !== 1'b0);
        expected_distances.push_back(capsule_distance(p, capsule_cfg));
    endtask

    task automatic send_xyz(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        point_t p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        send_point(p);
    endtask

    // sender goes quiet for a random stretch, each further idle step with pct percent chance
    task automatic sender_pause(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // wait until the pipeline owes nothing, the core is idle after that
    task automatic settle();
        if (start !== 1'b0)
            start <= 1'b0;
        while (expected_distances.size() != 0)
            @(posedge clk);
    endtask

    // signed offset in [-span, span]
    function automatic longint spread(input longint span);
        longint unsigned u;
        u = {$urandom(), $urandom()};
        return longint'(u % longint'(2 * span + 1)) - span;
    endfunction

    function automatic logic [31:0] random_coord();
        if ($urandom_range(1))
            return $urandom_range(0, 2000 << 16) - (1000 << 16);
        return $urandom();
    endfunction

    function automatic logic [31:0] random_extent();
        case ($urandom_range(4))
            0:       return '0;
            1:       return $urandom_range(1, 16 << 16);
            2:       return $urandom_range(1, 64);
            3:       return $urandom();
            default: return {1'b0, {(COORD_BITS-1){1'b1}}};
        endcase
    endfunction

    // mostly points around the capsule, some right on its surface, some anywhere
    function automatic point_t random_point();
        longint half, rad, ox, oy, oz;
        int     pick;
        point_t p;
        half = longint'(capsule_cfg.segment_length) / 2;
        rad  = longint'(capsule_cfg.cap_radius);
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            ox = spread(2 * rad + 16);
            oy = spread(half + 2 * rad + 16);
            oz = spread(2 * rad + 16);
        end
        else if (pick < 82)
        begin
            // on the surface, give or take one lsb
            ox = 0;
            oz = 0;
            oy = spread(half);
            case ($urandom_range(2))
                0:       ox = ($urandom_range(1) ? rad : -rad) + spread(1);
                1:       oz = ($urandom_range(1) ? rad : -rad) + spread(1);
                default: oy = ($urandom_range(1) ? half + rad : -half - rad) + spread(1);
            endcase
        end
        else
        begin
            p = {$urandom(), $urandom(), $urandom()};
            return p;
        end
        p.point_x = 32'(longint'(capsule_cfg.centre_x) + ox);
        p.point_y = 32'(longint'(capsule_cfg.centre_y) + oy);
        p.point_z = 32'(longint'(capsule_cfg.centre_z) + oz);
        return p;
    endfunction

    task automatic run_batch(input int count, input int pct);
        for (int i = 0; i < count; i++)
        begin
            send_point(random_point());
            sender_pause(pct);
        end
        settle();
    endtask

    // reset capsule is a unit sphere at the origin
    task automatic test_reset_sphere();
        send_xyz('0, '0, '0);
        send_xyz(ONE, '0, '0);
        send_xyz(ONE + 1, '0, '0);
        send_xyz('0, -ONE, '0);
        settle();
    endtask

    // extreme coordinates, zero and full radius, saturation of the distance
    task automatic test_extremes();
        write_reg(REG_CAP_RADIUS, '0);
        send_xyz(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_xyz(32'h8000_0000, '0, '0);
        settle();
        write_capsule(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff);
        send_xyz(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_xyz(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_xyz(32'h8000_0000, '0, 32'h8000_0000);
        settle();
    endtask

    // odd segment length: clamp to either end and the cylinder between
    task automatic test_segment_clamp();
        write_capsule(ONE, 2 * ONE, -3 * ONE, 32'd3, 2 * ONE);
        send_xyz(3 * ONE, 2 * ONE, -3 * ONE);
        send_xyz(ONE, 2 * ONE + 1, -ONE);
        send_xyz(ONE, 4 * ONE + 2, -3 * ONE);
        send_xyz(ONE, 2 * ONE - 2, -3 * ONE);
        settle();
    endtask

    // top bit of the unsigned registers is dropped, spare slot is ignored
    task automatic test_register_masking();
        write_reg(REG_SEG_LENGTH, 32'h800a_0000);
        write_reg(REG_CAP_RADIUS, 32'hffff_ffff);
        write_reg(REG_SPARE, $urandom());
        send_point(random_point());
        send_xyz($urandom(), $urandom(), $urandom());
        settle();
        write_capsule('0, '0, '0, 32'h800a_0000, 32'h8001_0000);
        write_reg(REG_SPARE, $urandom());
        send_xyz('0, 6 * ONE, '0);
        settle();
    endtask

    task automatic randomize_capsule();
        write_capsule(random_coord(), random_coord(), random_coord(),
                      random_extent(), random_extent());
    endtask

    // points back to back, no gaps at all
    task automatic test_random_streaming();
        for (int i = 0; i < 4; i++)
        begin
            randomize_capsule();
            run_batch(50, 0);
        end
    endtask

    // sender idle most of the time
    task automatic test_random_sparse();
        for (int i = 0; i < 3; i++)
        begin
            randomize_capsule();
            run_batch(50, 78);
        end
    endtask

    // occasional short gaps
    task automatic test_random_light_gaps();
        for (int i = 0; i < 3; i++)
        begin
            randomize_capsule();
            run_batch(50, 13);
        end
    endtask

    // short batches, fresh capsule and gap rate each time
    task automatic test_random_mixed();
        int rates[3] = '{0, 78, 13};
        for (int i = 0; i < 6; i++)
        begin
            randomize_capsule();
            run_batch(25, rates[i % 3]);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_sphere();
        test_extremes();
        test_segment_clamp();
        test_register_masking();
        test_random_streaming();
        test_random_sparse();
        test_random_light_gaps();
        test_random_mixed();
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_distances.size() == 0)
            $display("[point_capsule_distance_core] OK");
        else
            $display("[point_capsule_distance_core] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("[point_capsule_distance_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pcd_pkg.sv
rtl/pcd_regs.sv
rtl/pcd_front.sv
rtl/pcd_sqrt_cell.sv
rtl/point_capsule_distance_core.sv
sim/tb_top.sv
